// File: src/fks_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the keyframe selector.
// No dependencies; imported by every module of the block.
package fks_pkg;

    localparam int MAX_TRACKS    = 256;
    localparam int WINDOW_FRAMES = 10;
    localparam int SLOTS         = WINDOW_FRAMES + 1;
    localparam int LEN_CAP       = (SLOTS > 15) ? 15 : SLOTS;
    localparam int TRK_W         = $clog2(MAX_TRACKS);
    localparam int CNT_W         = $clog2(MAX_TRACKS + 1);
    localparam int SLOT_W        = 4;
    localparam int PT_AW         = TRK_W + SLOT_W;
    localparam int PT_DEPTH      = MAX_TRACKS * (2 ** SLOT_W);
    localparam int SUM_W         = 32 + TRK_W;

    localparam logic [15:0] MIN_PAR_RST = 16'd1425;
    localparam logic [9:0]  MIN_TRK_RST = 10'd20;
    localparam logic [8:0]  SAT9        = 9'd511;
    localparam logic [4:0]  WIN_LAST5   = 5'(WINDOW_FRAMES - 1);
    localparam logic [4:0]  USE_LIM5    = 5'(WINDOW_FRAMES - 2);
    localparam logic [4:0]  LEN_CAP5    = 5'(LEN_CAP);
    localparam logic [TRK_W-1:0] IDX_LAST = TRK_W'(MAX_TRACKS - 1);

    typedef enum logic [1:0] {
        OP_OBSERVE     = 2'd0,
        OP_END_FRAME   = 2'd1,
        OP_DROP_OLDEST = 2'd2,
        OP_DROP_SECOND = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_ZERO_DEPTH = 2'd2
    } t_status;

    localparam logic REG_MIN_PARALLAX = 1'b0;
    localparam logic REG_MIN_TRACKED  = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  start;
        logic [3:0]  length;
    } t_meta;

    typedef struct packed {
        logic             meta_rd;
        logic             meta_we;
        logic [TRK_W-1:0] meta_addr;
        t_meta            meta_wdata;
        logic             pt_rd;
        logic [PT_AW-1:0] pt_raddr;
        logic             pt_we;
        logic [PT_AW-1:0] pt_waddr;
        t_point           pt_wdata;
        logic             vld_set;
        logic             vld_clr;
        logic [TRK_W-1:0] vld_idx;
    } t_tbl_req;

    function automatic logic [PT_AW-1:0] pt_addr(input logic [TRK_W-1:0] trk,
                                                 input logic [SLOT_W-1:0] slot);
        return {trk, slot};
    endfunction

    function automatic logic is_usable(input logic [3:0] len, input logic [3:0] start);
        return (len >= 4'd2) && ({1'b0, start} < USE_LIM5);
    endfunction

    function automatic logic [8:0] sat9(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'(SAT9)) ? SAT9 : w[8:0];
    endfunction

endpackage

// File: src/fks_table.sv
`timescale 1ns / 1ps
// Track table: valid flags, per-track metadata memory and point memory.
// Depends on fks_pkg for sizes, request struct and record types.
module fks_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fks_pkg::t_tbl_req i_req,
    output fks_pkg::t_meta    o_meta,
    output fks_pkg::t_point   o_point,
    output logic              o_valid
);
    import fks_pkg::*;

    t_meta             r_meta_mem [MAX_TRACKS];
    t_point            r_pt_mem   [PT_DEPTH];
    logic [MAX_TRACKS-1:0] r_valid;
    t_meta             r_meta_q;
    t_point            r_pt_q;

    always_ff @(posedge i_clk) begin
        if (i_req.meta_we) begin
            r_meta_mem[i_req.meta_addr] <= i_req.meta_wdata;
        end
        if (i_req.meta_rd) begin
            r_meta_q <= r_meta_mem[i_req.meta_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pt_we) begin
            r_pt_mem[i_req.pt_waddr] <= i_req.pt_wdata;
        end
        if (i_req.pt_rd) begin
            r_pt_q <= r_pt_mem[i_req.pt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.vld_set) begin
            r_valid[i_req.vld_idx] <= 1'b1;
        end else if (i_req.vld_clr) begin
            r_valid[i_req.vld_idx] <= 1'b0;
        end
    end

    assign o_meta  = r_meta_q;
    assign o_point = r_pt_q;
    assign o_valid = r_valid[i_req.vld_idx];

endmodule

// File: src/fks_parallax.sv
`timescale 1ns / 1ps
// Iterative parallax unit: shared divider, one multiplier, bitwise square root.
// Depends on fks_pkg for the point record.
module fks_parallax (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fks_pkg::t_point i_pi,
    input  fks_pkg::t_point i_pj,
    output logic            o_done,
    output logic [31:0]     o_value,
    output logic            o_zero
);
    import fks_pkg::*;

    typedef enum logic [8:0] {
        P_IDLE = 9'b000000001,
        P_DIV  = 9'b000000010,
        P_SAT  = 9'b000000100,
        P_SUB  = 9'b000001000,
        P_SQA  = 9'b000010000,
        P_SQB  = 9'b000100000,
        P_ADD  = 9'b001000000,
        P_ROOT = 9'b010000000,
        P_DONE = 9'b100000000
    } t_pstate;

    t_pstate            r_st;
    logic [5:0]         r_cnt;
    logic               r_sel;
    logic               r_sign;
    logic [47:0]        r_num;
    logic [31:0]        r_den;
    logic [31:0]        r_rem;
    logic [47:0]        r_quo;
    logic signed [31:0] r_u;
    logic signed [31:0] r_v;
    logic [30:0]        r_a;
    logic [30:0]        r_b;
    logic [61:0]        r_acc;
    logic [61:0]        r_prod;
    logic [63:0]        r_rv;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_val;
    logic               r_zero;

    logic [32:0] rem_sh;
    logic        div_ge;
    logic [32:0] rem_nx;
    logic [31:0] q_sat;
    logic [30:0] mul_op;
    logic [61:0] mul;
    logic [63:0] root_t;
    logic        root_ge;
    logic [63:0] res_nx;
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;

    function automatic logic [31:0] mag32(input logic signed [31:0] s);
        return s[31] ? (~s + 32'd1) : s;
    endfunction

    function automatic logic [30:0] sat_abs(input logic signed [32:0] d);
        logic [32:0] nd;
        nd = d[32] ? (~d + 33'd1) : d;
        return (nd > 33'h07FFFFFFF) ? 31'h7FFFFFFF : nd[30:0];
    endfunction

    assign mag_x = mag32(i_pi.x);
    assign mag_y = mag32(i_pi.y);
    assign mag_z = mag32(i_pi.z);

    assign rem_sh = {r_rem, r_num[47]};
    assign div_ge = rem_sh >= {1'b0, r_den};
    assign rem_nx = div_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;

    always_comb begin
        if (r_sign) begin
            q_sat = (r_quo > 48'h000080000000) ? 32'h80000000 : (~r_quo[31:0] + 32'd1);
        end else begin
            q_sat = (r_quo > 48'h00007FFFFFFF) ? 32'h7FFFFFFF : r_quo[31:0];
        end
    end

    assign mul_op = (r_st == P_SQA) ? r_a : r_b;
    assign mul    = mul_op * mul_op;

    assign root_t  = r_res + r_bit;
    assign root_ge = r_rv >= root_t;
    assign res_nx  = root_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= P_IDLE;
        end else begin
            case (r_st)
                P_IDLE: begin
                    if (i_start) begin
                        if (i_pi.z == 32'sd0) begin
                            r_val  <= 32'hFFFFFFFF;
                            r_zero <= 1'b1;
                            r_st   <= P_DONE;
                        end else begin
                            r_zero <= 1'b0;
                            r_num  <= {mag_x, 16'd0};
                            r_den  <= mag_z;
                            r_rem  <= '0;
                            r_sign <= i_pi.x[31] ^ i_pi.z[31];
                            r_sel  <= 1'b0;
                            r_cnt  <= '0;
                            r_st   <= P_DIV;
                        end
                    end
                end
                P_DIV: begin
                    r_rem <= rem_nx[31:0];
                    r_num <= {r_num[46:0], 1'b0};
                    r_quo <= {r_quo[46:0], div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) begin
                        r_st <= P_SAT;
                    end
                end
                P_SAT: begin
                    if (!r_sel) begin
                        r_u    <= q_sat;
                        r_num  <= {mag_y, 16'd0};
                        r_rem  <= '0;
                        r_sign <= i_pi.y[31] ^ i_pi.z[31];
                        r_sel  <= 1'b1;
                        r_cnt  <= '0;
                        r_st   <= P_DIV;
                    end else begin
                        r_v  <= q_sat;
                        r_st <= P_SUB;
                    end
                end
                P_SUB: begin
                    r_a  <= sat_abs({r_u[31], r_u} - {i_pj.x[31], i_pj.x});
                    r_b  <= sat_abs({r_v[31], r_v} - {i_pj.y[31], i_pj.y});
                    r_st <= P_SQA;
                end
                P_SQA: begin
                    r_acc <= mul;
                    r_st  <= P_SQB;
                end
                P_SQB: begin
                    r_prod <= mul;
                    r_st   <= P_ADD;
                end
                P_ADD: begin
                    r_rv  <= {2'b00, r_acc} + {2'b00, r_prod};
                    r_res <= '0;
                    r_bit <= 64'h4000000000000000;
                    r_cnt <= '0;
                    r_st  <= P_ROOT;
                end
                P_ROOT: begin
                    if (root_ge) begin
                        r_rv <= r_rv - root_t;
                    end
                    r_res <= res_nx;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_val <= res_nx[31:0];
                        r_st  <= P_DONE;
                    end
                end
                P_DONE: begin
                    r_st <= P_IDLE;
                end
                default: begin
                    r_st <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_st == P_DONE);
    assign o_value = r_val;
    assign o_zero  = r_zero;

endmodule

// File: src/feature_track_keyframe_selector.sv
`timescale 1ns / 1ps
// Top level: table walker, APB registers and result register of the keyframe selector.
// Depends on fks_pkg, fks_table and fks_parallax.
//
// One item is in work at a time; the input is ready only when the sequencer is idle.
// Every operation but an early end-of-frame decision walks the track table, one track
// at a time through the metadata memory port. Observe stops at the first matching id,
// or walks every track when the id is new. End of frame adds, for each contributing
// track, the point reads and the parallax unit (two 48-step divisions and a 32-step
// square root); an early decision skips the walk. The drop operations also move the
// points above a dropped slot down one slot and rewrite the metadata of each changed
// track. No clearing pass is needed after reset.
module feature_track_keyframe_selector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_frame_count,
    input  logic [31:0] i_feature_id,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_keyframe,
    output logic [8:0]  o_tracked_count,
    output logic [8:0]  o_usable_count,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fks_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_META_RD  = 14'b00000000000010,
        S_META_EV  = 14'b00000000000100,
        S_PT_I     = 14'b00000000001000,
        S_PT_J     = 14'b00000000010000,
        S_PAR_GO   = 14'b00000000100000,
        S_PAR_WAIT = 14'b00000001000000,
        S_MOVE_RD  = 14'b00000010000000,
        S_MOVE_WR  = 14'b00000100000000,
        S_REM_END  = 14'b00001000000000,
        S_FINISH   = 14'b00010000000000,
        S_MUL      = 14'b00100000000000,
        S_KEY      = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } t_state;

    t_state             r_state, n_state;
    logic [TRK_W-1:0]   r_idx, n_idx;
    t_op                r_op, n_op;
    logic [3:0]         r_fc, n_fc;
    logic [31:0]        r_fid, n_fid;
    t_point             r_pt, n_pt;
    logic               r_hit, n_hit;
    logic               r_free_found, n_free_found;
    logic [TRK_W-1:0]   r_free, n_free;
    logic [8:0]         r_cont, n_cont;
    logic [CNT_W-1:0]   r_usable, n_usable;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_num, n_num;
    logic [16+CNT_W-1:0] r_prod, n_prod;
    logic [4:0]         r_k, n_k;
    t_point             r_pi, n_pi;
    t_point             r_pj, n_pj;
    logic               r_key, n_key;
    t_status            r_status, n_status;
    logic [15:0]        r_min_par;
    logic [9:0]         r_min_trk;
    logic               r_ov, n_ov;
    logic               r_o_key, n_o_key;
    logic [8:0]         r_o_trk, n_o_trk;
    logic [8:0]         r_o_use, n_o_use;
    t_status            r_o_st, n_o_st;

    t_tbl_req    req;
    t_meta       meta;
    t_point      pt_q;
    logic        vld;
    logic        par_start;
    logic        par_done;
    logic [31:0] par_value;
    logic        par_zero;

    logic        adv;
    logic [4:0]  s5;
    logic [4:0]  l5;
    logic [4:0]  fc5;
    logic [4:0]  k_new;
    logic [3:0]  len_m1;
    logic        in_acc;

    fks_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_meta  (meta),
        .o_point (pt_q),
        .o_valid (vld)
    );

    fks_parallax u_parallax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (par_start),
        .i_pi    (r_pi),
        .i_pj    (r_pj),
        .o_done  (par_done),
        .o_value (par_value),
        .o_zero  (par_zero)
    );

    assign s5     = {1'b0, meta.start};
    assign l5     = {1'b0, meta.length};
    assign fc5    = {1'b0, r_fc};
    assign k_new  = WIN_LAST5 - s5;
    assign len_m1 = meta.length - 4'd1;
    assign in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_op         = r_op;
        n_fc         = r_fc;
        n_fid        = r_fid;
        n_pt         = r_pt;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_cont       = r_cont;
        n_usable     = r_usable;
        n_sum        = r_sum;
        n_num        = r_num;
        n_prod       = r_prod;
        n_k          = r_k;
        n_pi         = r_pi;
        n_pj         = r_pj;
        n_key        = r_key;
        n_status     = r_status;
        n_ov         = r_ov && !i_out_ready;
        n_o_key      = r_o_key;
        n_o_trk      = r_o_trk;
        n_o_use      = r_o_use;
        n_o_st       = r_o_st;
        req          = '0;
        req.meta_addr = r_idx;
        req.vld_idx  = r_idx;
        par_start    = 1'b0;
        adv          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = t_op'(i_operation);
                    n_fc         = i_frame_count;
                    n_fid        = i_feature_id;
                    n_pt         = '{x: i_point_x, y: i_point_y, z: i_point_z};
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_sum        = '0;
                    n_num        = '0;
                    n_key        = 1'b0;
                    n_status     = ST_OK;
                    n_state      = S_META_RD;
                    case (t_op'(i_operation))
                        OP_END_FRAME: begin
                            if ((i_frame_count < 4'd2) || ({1'b0, r_cont} < r_min_trk)) begin
                                n_key   = 1'b1;
                                n_state = S_OUT;
                            end
                        end
                        OP_DROP_OLDEST, OP_DROP_SECOND: begin
                            n_usable = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_META_RD: begin
                req.meta_rd = 1'b1;
                n_state     = S_META_EV;
            end
            S_META_EV: begin
                case (r_op)
                    OP_OBSERVE: begin
                        if (vld && (meta.id == r_fid)) begin
                            n_hit   = 1'b1;
                            n_state = S_FINISH;
                        end else begin
                            if (!vld && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free       = r_idx;
                            end
                            adv = 1'b1;
                        end
                    end
                    OP_END_FRAME: begin
                        if (vld && ((s5 + 5'd2) <= fc5) && ((s5 + l5) >= fc5)) begin
                            req.pt_rd    = 1'b1;
                            req.pt_raddr = pt_addr(r_idx, r_fc - 4'd2 - meta.start);
                            n_state      = S_PT_I;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    OP_DROP_OLDEST: begin
                        if (!vld) begin
                            adv = 1'b1;
                        end else if (meta.start != 4'd0) begin
                            req.meta_we    = 1'b1;
                            req.meta_wdata = '{id: meta.id, start: meta.start - 4'd1,
                                               length: meta.length};
                            if (is_usable(meta.length, meta.start - 4'd1)) begin
                                n_usable = r_usable + CNT_W'(1);
                            end
                            adv = 1'b1;
                        end else begin
                            n_k     = 5'd0;
                            n_state = (5'd1 >= l5) ? S_REM_END : S_MOVE_RD;
                        end
                    end
                    default: begin
                        if (!vld) begin
                            adv = 1'b1;
                        end else if (meta.start == r_fc) begin
                            if (meta.start != 4'd0) begin
                                req.meta_we    = 1'b1;
                                req.meta_wdata = '{id: meta.id, start: meta.start - 4'd1,
                                                   length: meta.length};
                                if (is_usable(meta.length, meta.start - 4'd1)) begin
                                    n_usable = r_usable + CNT_W'(1);
                                end
                            end else if (is_usable(meta.length, meta.start)) begin
                                n_usable = r_usable + CNT_W'(1);
                            end
                            adv = 1'b1;
                        end else if (((s5 + l5) >= fc5) && (s5 <= WIN_LAST5)
                                     && (k_new < l5)) begin
                            n_k     = k_new;
                            n_state = ((k_new + 5'd1) >= l5) ? S_REM_END : S_MOVE_RD;
                        end else begin
                            if (is_usable(meta.length, meta.start)) begin
                                n_usable = r_usable + CNT_W'(1);
                            end
                            adv = 1'b1;
                        end
                    end
                endcase
            end
            S_PT_I: begin
                n_pi         = pt_q;
                req.pt_rd    = 1'b1;
                req.pt_raddr = pt_addr(r_idx, r_fc - 4'd1 - meta.start);
                n_state      = S_PT_J;
            end
            S_PT_J: begin
                n_pj    = pt_q;
                n_state = S_PAR_GO;
            end
            S_PAR_GO: begin
                par_start = 1'b1;
                n_state   = S_PAR_WAIT;
            end
            S_PAR_WAIT: begin
                if (par_done) begin
                    n_sum = r_sum + SUM_W'(par_value);
                    n_num = r_num + CNT_W'(1);
                    if (par_zero) begin
                        n_status = ST_ZERO_DEPTH;
                    end
                    adv = 1'b1;
                end
            end
            S_MOVE_RD: begin
                req.pt_rd    = 1'b1;
                req.pt_raddr = pt_addr(r_idx, r_k[3:0] + 4'd1);
                n_state      = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                req.pt_we    = 1'b1;
                req.pt_waddr = pt_addr(r_idx, r_k[3:0]);
                req.pt_wdata = pt_q;
                n_k          = r_k + 5'd1;
                n_state      = ((r_k + 5'd2) >= l5) ? S_REM_END : S_MOVE_RD;
            end
            S_REM_END: begin
                req.meta_we    = 1'b1;
                req.meta_wdata = '{id: meta.id, start: meta.start, length: len_m1};
                if (len_m1 == 4'd0) begin
                    req.vld_clr = 1'b1;
                end
                if (is_usable(len_m1, meta.start)) begin
                    n_usable = r_usable + CNT_W'(1);
                end
                adv = 1'b1;
            end
            S_FINISH: begin
                if (r_hit) begin
                    if (l5 < LEN_CAP5) begin
                        req.pt_we      = 1'b1;
                        req.pt_waddr   = pt_addr(r_idx, meta.length);
                        req.pt_wdata   = r_pt;
                        req.meta_we    = 1'b1;
                        req.meta_wdata = '{id: meta.id, start: meta.start,
                                           length: meta.length + 4'd1};
                        if ((meta.length == 4'd1) && is_usable(4'd2, meta.start)) begin
                            n_usable = r_usable + CNT_W'(1);
                        end
                    end
                    if (r_cont != SAT9) begin
                        n_cont = r_cont + 9'd1;
                    end
                end else if (r_free_found) begin
                    req.vld_set    = 1'b1;
                    req.vld_idx    = r_free;
                    req.meta_we    = 1'b1;
                    req.meta_addr  = r_free;
                    req.meta_wdata = '{id: r_fid, start: r_fc, length: 4'd1};
                    req.pt_we      = 1'b1;
                    req.pt_waddr   = pt_addr(r_free, 4'd0);
                    req.pt_wdata   = r_pt;
                end else begin
                    n_status = ST_TABLE_FULL;
                end
                n_state = S_OUT;
            end
            S_MUL: begin
                n_prod  = r_min_par * r_num;
                n_state = S_KEY;
            end
            S_KEY: begin
                n_key   = (r_num == '0) || (64'(r_sum) >= 64'(r_prod));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_o_key = r_key;
                    n_o_trk = r_cont;
                    n_o_use = sat9(r_usable);
                    n_o_st  = r_status;
                    if (r_op == OP_END_FRAME) begin
                        n_cont = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            if (r_idx == IDX_LAST) begin
                case (r_op)
                    OP_OBSERVE:   n_state = S_FINISH;
                    OP_END_FRAME: n_state = S_MUL;
                    default:      n_state = S_OUT;
                endcase
            end else begin
                n_idx   = r_idx + TRK_W'(1);
                n_state = S_META_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cont    <= '0;
            r_usable  <= '0;
            r_ov      <= 1'b0;
            r_min_par <= MIN_PAR_RST;
            r_min_trk <= MIN_TRK_RST;
        end else begin
            r_state  <= n_state;
            r_cont   <= n_cont;
            r_usable <= n_usable;
            r_ov     <= n_ov;
            if (psel && penable && pwrite) begin
                case (paddr[2])
                    REG_MIN_PARALLAX: r_min_par <= pwdata[15:0];
                    REG_MIN_TRACKED:  r_min_trk <= pwdata[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_op         <= n_op;
        r_fc         <= n_fc;
        r_fid        <= n_fid;
        r_pt         <= n_pt;
        r_hit        <= n_hit;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_sum        <= n_sum;
        r_num        <= n_num;
        r_prod       <= n_prod;
        r_k          <= n_k;
        r_pi         <= n_pi;
        r_pj         <= n_pj;
        r_key        <= n_key;
        r_status     <= n_status;
        r_o_key      <= n_o_key;
        r_o_trk      <= n_o_trk;
        r_o_use      <= n_o_use;
        r_o_st       <= n_o_st;
    end

    assign o_in_ready      = in_acc || (r_state == S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_is_keyframe   = r_o_key;
    assign o_tracked_count = r_o_trk;
    assign o_usable_count  = r_o_use;
    assign o_status        = r_o_st;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_MIN_TRACKED) ? {22'd0, r_min_trk}
                                                            : {16'd0, r_min_par};

endmodule
